// ===== sv/assert_macros.svh =====
// Assertion macros for the radar sweep trail renderer.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked at the same edge as the antecedent.
`define RSTR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked at the edge after the antecedent.
`define RSTR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rstr_pkg.sv =====
// Shared types, codes and tables of the radar sweep trail renderer.
// No dependencies; used by the front end, the back end and the top level.
package rstr_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_REDRAW = 2'd1,
		OP_DRAW   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_FULL   = 2'd0,
		KIND_REPAIR = 2'd1,
		KIND_LINE   = 2'd2,
		KIND_POINT  = 2'd3
	} kind_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] angle;
	} op_rec_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        angle;
		logic signed [9:0] x_end;
		logic signed [9:0] y_end;
		logic [15:0]       color;
		logic              last;
	} res_t;

	localparam logic [1:0] REG_CENTER_X         = 2'd0;
	localparam logic [1:0] REG_CENTER_Y         = 2'd1;
	localparam logic [1:0] REG_LINE_LENGTH      = 2'd2;
	localparam logic [1:0] REG_REFRESH_INTERVAL = 2'd3;

	localparam int OP_DEPTH  = 2;
	localparam int RES_DEPTH = 4;

	localparam logic [7:0]  NO_ANGLE  = 8'd255;
	localparam logic [15:0] COLOR_DIM = 16'h0120;
	localparam logic [15:0] COLOR_MID = 16'h0380;

	localparam logic [8:0] QUARTER_SINE [91] = '{
		9'd0,   9'd4,   9'd9,   9'd13,  9'd18,  9'd22,  9'd27,  9'd31,
		9'd36,  9'd40,  9'd44,  9'd49,  9'd53,  9'd58,  9'd62,  9'd66,
		9'd71,  9'd75,  9'd79,  9'd83,  9'd88,  9'd92,  9'd96,  9'd100,
		9'd104, 9'd108, 9'd112, 9'd116, 9'd120, 9'd124, 9'd128, 9'd132,
		9'd136, 9'd139, 9'd143, 9'd147, 9'd150, 9'd154, 9'd158, 9'd161,
		9'd165, 9'd168, 9'd171, 9'd175, 9'd178, 9'd181, 9'd184, 9'd187,
		9'd190, 9'd193, 9'd196, 9'd199, 9'd202, 9'd204, 9'd207, 9'd210,
		9'd212, 9'd215, 9'd217, 9'd219, 9'd222, 9'd224, 9'd226, 9'd228,
		9'd230, 9'd232, 9'd234, 9'd236, 9'd237, 9'd239, 9'd241, 9'd242,
		9'd243, 9'd245, 9'd246, 9'd247, 9'd248, 9'd249, 9'd250, 9'd251,
		9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255, 9'd256,
		9'd256, 9'd256, 9'd256
	};

	// Sine times 256 for deg in 0..359.
	function automatic logic signed [9:0] sine256(input logic [8:0] deg);
		logic [8:0] idx;
		logic       neg;
		logic [8:0] mag;
		if (deg <= 9'd90) begin
			idx = deg;
			neg = 1'b0;
		end else if (deg <= 9'd180) begin
			idx = 9'd180 - deg;
			neg = 1'b0;
		end else if (deg <= 9'd270) begin
			idx = deg - 9'd180;
			neg = 1'b1;
		end else begin
			idx = 9'd360 - deg;
			neg = 1'b1;
		end
		mag = QUARTER_SINE[idx[6:0]];
		return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	function automatic logic is_grid(input logic [7:0] a);
		return a inside {8'd30, 8'd60, 8'd90, 8'd120, 8'd150};
	endfunction

endpackage

// ===== sv/rstr_fifo.sv =====
// Small register queue with occupancy count.
// Generic; used for the operation queue and the result queue.
module rstr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [WIDTH-1:0]               wr_data,
	output logic                           full,
	input  logic                           rd_en,
	output logic [WIDTH-1:0]               rd_data,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_wr) - CW'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== sv/rstr_front.sv =====
// Front end: accepts frame items, checks the refresh interval, classifies.
// Depends on rstr_pkg; feeds the operation queue.
module rstr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              cmd,
	input  logic [7:0]        sweep_angle,
	input  logic [31:0]       time_ms,
	input  logic [31:0]       refresh_interval,
	input  logic              q_full,
	output logic              q_push,
	output rstr_pkg::op_rec_t q_data
);

	logic [31:0] last_refresh_q;
	logic [31:0] elapsed;
	logic        stale;

	assign full    = q_full;
	assign q_push  = push & ~q_full;
	assign elapsed = time_ms - last_refresh_q;
	assign stale   = elapsed > refresh_interval;

	always_comb begin
		q_data.angle = sweep_angle;
		if (cmd) begin
			q_data.op = rstr_pkg::OP_CLEAR;
		end else if (stale) begin
			q_data.op = rstr_pkg::OP_REDRAW;
		end else begin
			q_data.op = rstr_pkg::OP_DRAW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_refresh_q <= '0;
		end else if (q_push && !cmd && stale) begin
			last_refresh_q <= time_ms;
		end
	end

endmodule

// ===== sv/rstr_back.sv =====
// Back end: trail store, per-frame sequencer and endpoint pipeline.
// Depends on rstr_pkg; reads the operation queue, writes the result queue.
module rstr_back #(
	parameter int TRAIL_DEPTH = 18
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [7:0]                             center_x,
	input  logic [7:0]                             center_y,
	input  logic [6:0]                             line_length,
	input  logic                                   op_empty,
	input  rstr_pkg::op_rec_t                      op_data,
	output logic                                   op_pop,
	input  logic [$clog2(rstr_pkg::RES_DEPTH+1)-1:0] res_count,
	output logic                                   res_push,
	output rstr_pkg::res_t                         res_data
);

	localparam int AW  = $clog2(TRAIL_DEPTH);
	localparam int CW  = $clog2(TRAIL_DEPTH + 1);
	localparam int RCW = $clog2(rstr_pkg::RES_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(TRAIL_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(TRAIL_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_REP   = 5'b00010,
		S_LINE  = 5'b00100,
		S_GLINE = 5'b01000,
		S_GPT   = 5'b10000
	} state_t;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	logic [7:0]    ang_q [TRAIL_DEPTH];
	logic [AW-1:0] age_q [TRAIL_DEPTH];
	logic [5:0]    green_tbl [TRAIL_DEPTH];
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    prev_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    rm_ang_q;
	logic          grid_q;
	state_t        state_q;

	state_t          state_d;
	logic [AW-1:0]   idx_d;
	logic [RCW:0]    used;
	logic            can_issue;
	logic [AW-1:0]   old_age;
	logic [7:0]      old_ang;
	logic            rm;
	logic [AW-1:0]   head_n;
	logic [CW-1:0]   cnt_r;
	logic [CW-1:0]   cnt_n;
	logic            app;
	logic [AW-1:0]   app_slot;
	logic [AW-1:0]   line_slot;
	logic            line_end;

	logic            issue;
	rstr_pkg::kind_t req_kind;
	logic [7:0]      req_angle;
	logic [15:0]     req_color;
	logic            req_last;

	logic            v_s1;
	rstr_pkg::kind_t kind_s1;
	logic [7:0]      angle_s1;
	logic [15:0]     color_s1;
	logic            last_s1;

	logic               v_s2;
	rstr_pkg::kind_t    kind_s2;
	logic [7:0]         angle_s2;
	logic [15:0]        color_s2;
	logic               last_s2;
	logic signed [17:0] px_s2;
	logic signed [17:0] py_s2;

	logic signed [9:0]  sin_c;
	logic signed [9:0]  cos_c;
	logic signed [7:0]  len_c;
	logic signed [17:0] px_c;
	logic signed [17:0] py_c;
	logic signed [17:0] px_adj;
	logic signed [17:0] py_adj;
	logic signed [9:0]  qx;
	logic signed [9:0]  qy;

	for (genvar g = 0; g < TRAIL_DEPTH; g++) begin : g_green
		localparam int SHADE = 63 - (g * 62) / (TRAIL_DEPTH - 1);
		assign green_tbl[g] = 6'((SHADE < 1) ? 1 : SHADE);
	end

	assign used      = {1'b0, res_count} + (RCW + 1)'(v_s1) + (RCW + 1)'(v_s2);
	assign can_issue = used < (RCW + 1)'(rstr_pkg::RES_DEPTH);

	assign old_age   = age_q[head_q];
	assign old_ang   = ang_q[head_q];
	assign rm        = (cnt_q != '0) && (({1'b0, old_age} + 1'b1) >= DEPTH_W);
	assign head_n    = rm ? wrap_add(head_q, AW'(1)) : head_q;
	assign cnt_r     = cnt_q - CW'(rm);
	assign app       = (op_data.angle != prev_q) && (cnt_r < DEPTH_C);
	assign app_slot  = wrap_add(head_n, cnt_r[AW-1:0]);
	assign cnt_n     = cnt_r + CW'(app);
	assign line_slot = wrap_add(head_q, idx_q);
	assign line_end  = (CW'(idx_q) == cnt_q - CW'(1));

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		op_pop    = 1'b0;
		issue     = 1'b0;
		req_kind  = rstr_pkg::KIND_FULL;
		req_angle = '0;
		req_color = '0;
		req_last  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (!op_empty && can_issue) begin
					op_pop = 1'b1;
					idx_d  = '0;
					case (op_data.op)
						rstr_pkg::OP_REDRAW: begin
							issue    = 1'b1;
							req_last = 1'b1;
						end
						rstr_pkg::OP_DRAW: begin
							if (rm) begin
								state_d = S_REP;
							end else if (cnt_n != '0) begin
								state_d = S_LINE;
							end
						end
						default: ;
					endcase
				end
			end
			S_REP: begin
				if (can_issue) begin
					issue     = 1'b1;
					req_kind  = rstr_pkg::KIND_REPAIR;
					req_angle = rm_ang_q;
					req_last  = (cnt_q == '0) && !grid_q;
					if (cnt_q != '0) begin
						state_d = S_LINE;
					end else if (grid_q) begin
						state_d = S_GLINE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_LINE: begin
				if (can_issue) begin
					issue     = 1'b1;
					req_kind  = rstr_pkg::KIND_LINE;
					req_angle = ang_q[line_slot];
					req_color = {5'b0, green_tbl[age_q[line_slot]], 5'b0};
					req_last  = line_end && !grid_q;
					if (line_end) begin
						idx_d   = '0;
						state_d = grid_q ? S_GLINE : S_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			S_GLINE: begin
				if (can_issue) begin
					issue     = 1'b1;
					req_kind  = rstr_pkg::KIND_LINE;
					req_angle = rm_ang_q;
					req_color = rstr_pkg::COLOR_DIM;
					state_d   = S_GPT;
				end
			end
			S_GPT: begin
				if (can_issue) begin
					issue     = 1'b1;
					req_kind  = rstr_pkg::KIND_POINT;
					req_color = rstr_pkg::COLOR_MID;
					req_last  = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			head_q  <= '0;
			cnt_q   <= '0;
			prev_q  <= rstr_pkg::NO_ANGLE;
			grid_q  <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			if (op_pop) begin
				case (op_data.op)
					rstr_pkg::OP_DRAW: begin
						head_q <= head_n;
						cnt_q  <= cnt_n;
						grid_q <= rm && rstr_pkg::is_grid(old_ang);
						if (app) begin
							prev_q <= op_data.angle;
						end
					end
					default: begin
						cnt_q  <= '0;
						prev_q <= rstr_pkg::NO_ANGLE;
						grid_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && op_data.op == rstr_pkg::OP_DRAW) begin
			rm_ang_q <= old_ang;
			for (int i = 0; i < TRAIL_DEPTH; i++) begin
				if (app && app_slot == AW'(i)) begin
					age_q[i] <= '0;
				end else begin
					age_q[i] <= age_q[i] + 1'b1;
				end
			end
			if (app) begin
				ang_q[app_slot] <= op_data.angle;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_s1  <= req_kind;
		angle_s1 <= req_angle;
		color_s1 <= req_color;
		last_s1  <= req_last;
	end

	assign sin_c = rstr_pkg::sine256({1'b0, angle_s1});
	assign cos_c = rstr_pkg::sine256({1'b0, angle_s1} + 9'd90);
	assign len_c = $signed({1'b0, line_length});
	assign px_c  = len_c * cos_c;
	assign py_c  = len_c * sin_c;

	always_ff @(posedge clk) begin
		kind_s2  <= kind_s1;
		angle_s2 <= angle_s1;
		color_s2 <= color_s1;
		last_s2  <= last_s1;
		px_s2    <= px_c;
		py_s2    <= py_c;
	end

	assign px_adj = px_s2 + (px_s2[17] ? 18'sd255 : 18'sd0);
	assign py_adj = py_s2 + (py_s2[17] ? 18'sd255 : 18'sd0);
	assign qx     = $signed(px_adj[17:8]);
	assign qy     = $signed(py_adj[17:8]);

	assign res_push = v_s2;

	always_comb begin
		res_data.kind  = kind_s2;
		res_data.angle = angle_s2;
		res_data.color = color_s2;
		res_data.last  = last_s2;
		case (kind_s2)
			rstr_pkg::KIND_LINE: begin
				res_data.x_end = $signed({2'b00, center_x}) + qx;
				res_data.y_end = $signed({2'b00, center_y}) - qy;
			end
			rstr_pkg::KIND_POINT: begin
				res_data.x_end = $signed({2'b00, center_x});
				res_data.y_end = $signed({2'b00, center_y});
			end
			default: begin
				res_data.x_end = '0;
				res_data.y_end = '0;
			end
		endcase
	end

endmodule

// ===== sv/radar_sweep_trail_renderer.sv =====
// Radar sweep trail renderer top level: config registers, queues, front and back.
// Depends on rstr_pkg, rstr_fifo, rstr_front, rstr_back and assert_macros.svh.
//
// Usage: write center_x, center_y, line_length and refresh_interval through
// cfg_we/cfg_index/cfg_data while idle. Push one frame item (cmd, sweep_angle,
// time_ms) per beat while full is low; pop drawing commands while empty is low.
// Each frame yields zero to TRAIL_DEPTH + 3 commands; last marks the final one.
// A two-entry operation queue sits between the item classifier and the trail
// sequencer, so items are taken while earlier frames are still being drawn.
// The sequencer updates the trail as it takes an item, then issues one command
// per cycle while the result queue has room. A frame's first command is issued
// after its update, a full redraw in the cycle it is taken from the queue; each
// command then passes the s1 and s2 registers before it enters the result queue.
// A four-entry result queue with credit-based issue absorbs receiver stalls;
// when it fills, the sequencer holds and the operation queue backs up to full.
// Reset empties the trail, clears both queues and restores register defaults.
`include "assert_macros.svh"

module radar_sweep_trail_renderer #(
	parameter int TRAIL_DEPTH = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              cmd,
	input  logic [7:0]        sweep_angle,
	input  logic [31:0]       time_ms,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        kind,
	output logic [7:0]        angle,
	output logic signed [9:0] x_end,
	output logic signed [9:0] y_end,
	output logic [15:0]       color,
	output logic              last,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int RCW = $clog2(rstr_pkg::RES_DEPTH + 1);
	localparam int OCW = $clog2(rstr_pkg::OP_DEPTH + 1);

	logic [7:0]  center_x_q;
	logic [7:0]  center_y_q;
	logic [6:0]  line_length_q;
	logic [31:0] refresh_interval_q;

	logic              op_full;
	logic              op_push;
	rstr_pkg::op_rec_t op_wr;
	logic              op_empty;
	logic              op_pop;
	rstr_pkg::op_rec_t op_rd;
	logic [OCW-1:0]    op_count;

	logic              res_full;
	logic              res_push;
	rstr_pkg::res_t    res_wr;
	rstr_pkg::res_t    res_rd;
	logic [RCW-1:0]    res_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q         <= 8'd80;
			center_y_q         <= 8'd100;
			line_length_q      <= 7'd72;
			refresh_interval_q <= 32'd60000;
		end else if (cfg_we) begin
			case (cfg_index)
				rstr_pkg::REG_CENTER_X:         center_x_q         <= cfg_data[7:0];
				rstr_pkg::REG_CENTER_Y:         center_y_q         <= cfg_data[7:0];
				rstr_pkg::REG_LINE_LENGTH:      line_length_q      <= cfg_data[6:0];
				rstr_pkg::REG_REFRESH_INTERVAL: refresh_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rstr_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.cmd              (cmd),
		.sweep_angle      (sweep_angle),
		.time_ms          (time_ms),
		.refresh_interval (refresh_interval_q),
		.q_full           (op_full),
		.q_push           (op_push),
		.q_data           (op_wr)
	);

	rstr_fifo #(
		.WIDTH ($bits(rstr_pkg::op_rec_t)),
		.DEPTH (rstr_pkg::OP_DEPTH)
	) u_op_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_push),
		.wr_data (op_wr),
		.full    (op_full),
		.rd_en   (op_pop),
		.rd_data (op_rd),
		.empty   (op_empty),
		.count   (op_count)
	);

	rstr_back #(
		.TRAIL_DEPTH (TRAIL_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.center_x    (center_x_q),
		.center_y    (center_y_q),
		.line_length (line_length_q),
		.op_empty    (op_empty),
		.op_data     (op_rd),
		.op_pop      (op_pop),
		.res_count   (res_count),
		.res_push    (res_push),
		.res_data    (res_wr)
	);

	rstr_fifo #(
		.WIDTH ($bits(rstr_pkg::res_t)),
		.DEPTH (rstr_pkg::RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rd),
		.empty   (empty),
		.count   (res_count)
	);

	assign kind  = res_rd.kind;
	assign angle = res_rd.angle;
	assign x_end = res_rd.x_end;
	assign y_end = res_rd.y_end;
	assign color = res_rd.color;
	assign last  = res_rd.last;

	`RSTR_ASSERT_NOW(a_res_no_overflow, res_push, !res_full, "result queue overflow")
	`RSTR_ASSERT_NOW(a_op_no_underflow, op_pop, !op_empty, "operation queue underflow")
	`RSTR_ASSERT_NOW(a_redraw_is_last, res_push && res_wr.kind == rstr_pkg::KIND_FULL, res_wr.last, "full redraw not marked last")
	`RSTR_ASSERT_NEXT(a_op_lands, push && !full, !op_empty && op_count != '0, "accepted item missing from operation queue")

endmodule
